@@ design/pgcd_pkg.sv @@
// pgcd_pkg: types and constants for the pinch glove contact decoder
// no dependencies; imported by pinch_glove_contact_decoder
package pgcd_pkg;

  localparam logic [7:0] START_BYTE  = 8'h80;
  localparam logic [7:0] END_BYTE    = 8'h8F;
  localparam logic [7:0] THUMB_BIT   = 8'h10;
  localparam int unsigned NUM_BTN    = 8;
  localparam int unsigned BTN_IDX_W  = 3;

  typedef logic [3:0] finger_mask_t;
  typedef logic [NUM_BTN-1:0] btn_vec_t;
  typedef logic [BTN_IDX_W-1:0] btn_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } parse_phase_t;

  // finger j sits at mask bit 3-j, buttons count up from the index finger
  function automatic btn_vec_t to_buttons(input finger_mask_t left_m,
                                          input finger_mask_t right_m);
    btn_vec_t v;
    for (int j = 0; j < 4; j++) begin
      v[j]     = left_m[3-j];
      v[4 + j] = right_m[3-j];
    end
    return v;
  endfunction

endpackage

@@ design/pinch_glove_contact_decoder.sv @@
// pinch_glove_contact_decoder: byte stream parser and button event emitter
// depends on pgcd_pkg
//
// Decodes the serial byte stream of a two-hand pinch glove into button
// events. Idle bytes other than the start byte 0x80 are dropped. After a
// start byte the bytes are taken as (left, right) pairs until the end byte
// 0x8F shows up in the first-of-pair slot. A pair with only one nonzero
// byte that carries the thumb bit 0x10 ORs its four finger bits into that
// hand's pending mask. At the end byte the pending masks become the held
// masks; with report_enable set, every changed button yields one beat on
// the out_ channel (index hand*4+finger, new state, last flag), ascending
// by index. The parser takes one byte per clock while in_stall is low and
// updates its state in the cycle of acceptance. An end byte that changes
// buttons loads an event burst register that drains one event per clock
// into the output register unless out_stall holds that register; in_stall
// is high while that burst still holds events, so such a byte stalls the
// input until the burst is empty. report_enable is written through the
// cfg_ channel, which is always ready.
module pinch_glove_contact_decoder (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_report_enable,
  // byte input
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_rx_byte,
  // event output
  output logic                     out_valid,
  input  logic                     out_stall,
  output pgcd_pkg::btn_idx_t       out_button_index,
  output logic                     out_pressed,
  output logic                     out_last_event
);
  import pgcd_pkg::*;

  logic          report_en_r;
  parse_phase_t  phase_r, phase_nxt;
  logic [7:0]    first_r, first_nxt;
  finger_mask_t  pend_l_r, pend_l_nxt;
  finger_mask_t  pend_r_r, pend_r_nxt;
  finger_mask_t  held_l_r, held_l_nxt;
  finger_mask_t  held_r_r, held_r_nxt;
  btn_vec_t      burst_r, burst_nxt;     // buttons still to report
  btn_vec_t      bstate_r, bstate_nxt;   // new state of each button
  logic          out_valid_r, out_valid_nxt;
  btn_idx_t      out_idx_r, out_idx_nxt;
  logic          out_pr_r, out_pr_nxt;
  logic          out_last_r, out_last_nxt;

  logic          in_beat;
  logic          out_free;
  logic          burst_busy;
  btn_idx_t      pick_idx;
  btn_vec_t      burst_rest;
  btn_vec_t      delta;
  logic [7:0]    b;

  assign cfg_ready  = 1'b1;
  assign burst_busy = (burst_r != '0);
  assign in_stall   = burst_busy;
  assign in_beat    = in_valid && !in_stall;
  assign b          = in_rx_byte;

  // pending vs held difference, in button order
  assign delta = to_buttons(pend_l_r ^ held_l_r, pend_r_r ^ held_r_r);

  // ---------------------------------------------------------------------
  // parser: state updates in the cycle a byte is accepted
  // ---------------------------------------------------------------------
  always_comb begin
    phase_nxt  = phase_r;
    first_nxt  = first_r;
    pend_l_nxt = pend_l_r;
    pend_r_nxt = pend_r_r;
    held_l_nxt = held_l_r;
    held_r_nxt = held_r_r;
    burst_nxt  = burst_r;
    bstate_nxt = bstate_r;
    if (in_beat) begin
      case (phase_r)
        PH_FIRST: begin
          if (b == END_BYTE) begin
            // message end: latch events, pending masks become held
            burst_nxt  = report_en_r ? delta : '0;
            bstate_nxt = to_buttons(pend_l_r, pend_r_r);
            held_l_nxt = pend_l_r;
            held_r_nxt = pend_r_r;
            pend_l_nxt = '0;
            pend_r_nxt = '0;
            phase_nxt  = PH_IDLE;
          end else begin
            first_nxt = b;
            phase_nxt = PH_SECOND;
          end
        end
        PH_SECOND: begin
          // only a single-handed contact with the thumb bit counts
          if (first_r != 8'h00 && b == 8'h00) begin
            if ((first_r & THUMB_BIT) != 8'h00) begin
              pend_l_nxt = pend_l_r | first_r[3:0];
            end
          end else if (first_r == 8'h00 && b != 8'h00) begin
            if ((b & THUMB_BIT) != 8'h00) begin
              pend_r_nxt = pend_r_r | b[3:0];
            end
          end
          phase_nxt = PH_FIRST;
        end
        default: begin
          // idle, and the unused phase code behaves the same
          if (b == START_BYTE) begin
            pend_l_nxt = '0;
            pend_r_nxt = '0;
            phase_nxt  = PH_FIRST;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      endcase
    end

    // draining the burst; never overlaps a load since input stalls
    if (burst_busy && out_free) begin
      burst_nxt = burst_rest;
    end
  end

  // ---------------------------------------------------------------------
  // event picker: lowest pending button goes out next
  // ---------------------------------------------------------------------
  always_comb begin
    pick_idx = '0;
    for (int i = NUM_BTN - 1; i >= 0; i--) begin
      if (burst_r[i]) begin
        pick_idx = BTN_IDX_W'(i);
      end
    end
  end

  assign burst_rest = burst_r & (burst_r - btn_vec_t'(1));
  assign out_free   = !out_valid_r || !out_stall;

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_pr_nxt    = out_pr_r;
    out_last_nxt  = out_last_r;
    if (out_free) begin
      out_valid_nxt = burst_busy;
      if (burst_busy) begin
        out_idx_nxt  = pick_idx;
        out_pr_nxt   = bstate_r[pick_idx];
        out_last_nxt = (burst_rest == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_en_r <= 1'b0;
      phase_r     <= PH_IDLE;
      first_r     <= '0;
      pend_l_r    <= '0;
      pend_r_r    <= '0;
      held_l_r    <= '0;
      held_r_r    <= '0;
      burst_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        report_en_r <= cfg_report_enable;
      end
      phase_r     <= phase_nxt;
      first_r     <= first_nxt;
      pend_l_r    <= pend_l_nxt;
      pend_r_r    <= pend_r_nxt;
      held_l_r    <= held_l_nxt;
      held_r_r    <= held_r_nxt;
      burst_r     <= burst_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    bstate_r   <= bstate_nxt;
    out_idx_r  <= out_idx_nxt;
    out_pr_r   <= out_pr_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_button_index = out_idx_r;
  assign out_pressed      = out_pr_r;
  assign out_last_event   = out_last_r;

`ifndef SYNTHESIS
  // an event that is not the last of its burst always has a successor queued
  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_event) |-> (burst_r != '0))
    else $error("non-final event without queued successor");

  // a burst only appears after an accepted byte
  a_burst_source: assert property (@(posedge clk) disable iff (!rst_n)
    ((burst_r != '0) && ($past(burst_r) == '0)) |-> $past(in_valid && !in_stall))
    else $error("event burst loaded without an input beat");

  // the last event of a burst matches the held state of its button
  a_event_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_event && (burst_r == '0) && (phase_r == PH_IDLE)
     && !$past(in_valid && !in_stall)) |-> (out_pressed ==
      ((out_button_index[2]) ? held_r_r[3 - out_button_index[1:0]]
                             : held_l_r[3 - out_button_index[1:0]])))
    else $error("event state disagrees with held mask");
`endif

endmodule

@@ test/pinch_glove_contact_decoder_tb.sv @@
// pinch_glove_contact_decoder_tb: self-checking bench for the glove byte parser and its event burst
// depends on pgcd_pkg and pinch_glove_contact_decoder; drives glove bytes and report_enable,
// predicts the button events inline and checks every out_ beat in order
`timescale 1ns / 100ps

module pinch_glove_contact_decoder_tb;
  import pgcd_pkg::*;

  typedef struct packed {
    btn_idx_t index;
    logic     pressed;
    logic     last;
  } button_event_t;

  // clock and reset
  logic clk;
  logic rst_n = 1'b0;

  // configuration channel
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_report_enable = 1'b0;

  // byte channel
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;

  // event channel
  logic     out_valid;
  logic     out_stall = 1'b0;
  btn_idx_t out_button_index;
  logic     out_pressed;
  logic     out_last_event;

  // stimulus and scoreboard
  logic [7:0]    glove_bytes [$];
  button_event_t button_events_due [$];
  int            bytes_queued = 0;
  int            bytes_accepted = 0;
  int            events_checked = 0;
  int            enable_writes = 0;
  int            errors = 0;
  int            in_gap = 0;
  int            stall_left = 0;
  logic          calm = 1'b0;
  int            calm_left = 0;

  // shadow of the decoder state
  parse_phase_t phase_m = PH_IDLE;
  logic [7:0]   pair_left = 8'h00;
  finger_mask_t pend_m [2] = '{4'h0, 4'h0};
  finger_mask_t held_m [2] = '{4'h0, 4'h0};
  logic         report_on = 1'b0;

  pinch_glove_contact_decoder uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_report_enable (cfg_report_enable),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_button_index  (out_button_index),
    .out_pressed       (out_pressed),
    .out_last_event    (out_last_event)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // advance the shadow parser by one accepted byte, queue the events it causes
  task automatic parse_glove_byte(input logic [7:0] b);
    finger_mask_t  delta;
    button_event_t ev;
    button_event_t burst [$];
    case (phase_m)
      PH_FIRST: begin
        if (b == END_BYTE) begin
          // message end: one event per changed finger, left hand first, index finger first
          for (int h = 0; h < 2; h++) begin
            delta = pend_m[h] ^ held_m[h];
            for (int j = 0; j < 4; j++) begin
              if (delta[3-j] && report_on) begin
                ev.index   = btn_idx_t'(h * 4 + j);
                ev.pressed = pend_m[h][3-j];
                ev.last    = 1'b0;
                burst.push_back(ev);
              end
            end
          end
          if (burst.size() > 0) begin
            ev = burst.pop_back();
            ev.last = 1'b1;
            burst.push_back(ev);
          end
          foreach (burst[k]) button_events_due.push_back(burst[k]);
          // held masks follow even with reporting off
          held_m[0] = pend_m[0];
          held_m[1] = pend_m[1];
          pend_m[0] = 4'h0;
          pend_m[1] = 4'h0;
          phase_m = PH_IDLE;
        end else begin
          pair_left = b;
          phase_m = PH_SECOND;
        end
      end
      PH_SECOND: begin
        // only a pair with exactly one nonzero byte carrying the thumb bit counts
        if (pair_left != 8'h00 && b == 8'h00) begin
          if ((pair_left & THUMB_BIT) != 8'h00) pend_m[0] = pend_m[0] | pair_left[3:0];
        end else if (pair_left == 8'h00 && b != 8'h00) begin
          if ((b & THUMB_BIT) != 8'h00) pend_m[1] = pend_m[1] | b[3:0];
        end
        phase_m = PH_FIRST;
      end
      default: begin
        if (b == START_BYTE) begin
          pend_m[0] = 4'h0;
          pend_m[1] = 4'h0;
          phase_m = PH_FIRST;
        end else begin
          phase_m = PH_IDLE;
        end
      end
    endcase
  endtask

  // gap length for either side: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // alternate stretches with and without idling
  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm <= ($urandom_range(0, 3) == 0);
      calm_left <= $urandom_range(50, 400);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  // byte driver: one beat at a time from glove_bytes, held while stalled
  always @(posedge clk) begin : byte_driver
    logic       nv;
    logic [7:0] nb;
    nv = in_valid;
    nb = in_rx_byte;
    if (!rst_n) begin
      nv = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_glove_byte(in_rx_byte);
        bytes_accepted++;
        nv = 1'b0;
        in_gap = pick_gap();
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (glove_bytes.size() > 0) begin
          nv = 1'b1;
          nb = glove_bytes.pop_front();
        end
      end
    end
    in_valid <= nv;
    in_rx_byte <= nb;
  end

  // event monitor: compare each accepted beat with the oldest predicted event
  always @(posedge clk) begin : event_monitor
    logic          ns;
    button_event_t want;
    ns = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (button_events_due.size() == 0) begin
          $display("%0t: unexpected button event: got idx=%0d pressed=%0b last=%0b",
                   $time, out_button_index, out_pressed, out_last_event);
          errors++;
        end else begin
          want = button_events_due.pop_front();
          if (out_button_index !== want.index || out_pressed !== want.pressed ||
              out_last_event !== want.last) begin
            $display("%0t: button event mismatch: expected idx=%0d pressed=%0b last=%0b, got idx=%0d pressed=%0b last=%0b",
                     $time, want.index, want.pressed, want.last,
                     out_button_index, out_pressed, out_last_event);
            errors++;
          end
          events_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        ns = 1'b1;
      end else begin
        stall_left = pick_gap();
        if (stall_left > 0) begin
          stall_left--;
          ns = 1'b1;
        end
      end
    end
    out_stall <= ns;
  end

  task automatic put(input logic [7:0] b);
    glove_bytes.push_back(b);
    bytes_queued++;
  endtask

  // a contact byte, thumb bit mostly set, upper bits random
  function automatic logic [7:0] contact_byte();
    logic [7:0] b;
    b = 8'($urandom);
    b[4] = ($urandom_range(0, 99) < 85);
    return b;
  endfunction

  // random messages until about target bytes have gone to the parser
  task automatic queue_random_phase(input int target);
    int         count;
    int         r;
    int         n;
    logic [7:0] b;
    count = 0;
    while (count < target) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // idle noise, dropped by the parser unless a broken message left it mid-message
        repeat ($urandom_range(1, 3)) begin
          b = 8'($urandom);
          if (b == START_BYTE) b = 8'h81;
          put(b);
        end
      end else if (r < 18) begin
        // broken message: no end byte is queued, so the next start usually lands as pair data
        put(START_BYTE);
        n = $urandom_range(1, 6);
        repeat (n) put(8'($urandom));
        count += n + 1;
      end else begin
        put(START_BYTE);
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
        repeat (n) begin
          r = $urandom_range(0, 9);
          if (r < 4) begin
            put(contact_byte());
            put(8'h00);
          end else if (r < 7) begin
            put(8'h00);
            put(contact_byte());
          end else if (r == 7) begin
            put(8'h00);
            put(8'h00);
          end else if (r == 8) begin
            put(contact_byte() | 8'h01);
            put(contact_byte() | 8'h01);
          end else begin
            put(8'($urandom));
            put(8'($urandom));
          end
        end
        put(END_BYTE);
        count += 2 * n + 2;
      end
    end
  endtask

  // wait until every byte is taken and every event has come out, then a short tail
  task automatic drain();
    int waited;
    waited = 0;
    while ((bytes_accepted != bytes_queued || button_events_due.size() != 0) &&
           waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    if (bytes_accepted != bytes_queued || button_events_due.size() != 0) begin
      $display("%0t: stuck with %0d bytes not taken and %0d button events missing",
               $time, bytes_queued - bytes_accepted, button_events_due.size());
      errors++;
      button_events_due.delete();
    end
    // idle tail before the next phase starts
    repeat (20) @(posedge clk);
  endtask

  task automatic write_report_enable(input logic v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_report_enable <= v;
    do @(posedge clk); while (!cfg_ready);
    report_on = v;
    enable_writes++;
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic enables [6];
    enables = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reporting off after reset: masks still get stored, nothing comes out
    put(8'h00);
    put(START_BYTE);
    put(8'h1F);
    put(8'h00);
    put(END_BYTE);
    put(END_BYTE);
    drain();

    write_report_enable(1'b1);
    // left hand released, right hand fully closed: the biggest burst
    put(START_BYTE);
    put(8'h00);
    put(8'h1F);
    put(END_BYTE);
    // start byte as left data, 0xff with the upper bits dropped, both bytes set,
    // end byte in the right slot as plain data, then the real end
    put(START_BYTE);
    put(START_BYTE);
    put(8'h00);
    put(8'hFF);
    put(8'h00);
    put(8'h11);
    put(8'h11);
    put(8'h00);
    put(END_BYTE);
    put(END_BYTE);
    // empty message releases everything
    put(START_BYTE);
    put(END_BYTE);
    drain();

    foreach (enables[p]) begin
      if (enables[p] != report_on) write_report_enable(enables[p]);
      queue_random_phase(65);
      drain();
    end

    $display("covered %0d glove bytes and %0d button events, %0d report_enable writes",
             bytes_accepted, events_checked, enable_writes);
    if (errors == 0) begin
      $display("pinch_glove_contact_decoder_tb passed");
    end else begin
      $display("pinch_glove_contact_decoder_tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("%0t: timeout", $time);
    $display("pinch_glove_contact_decoder_tb failed");
    $finish;
  end

endmodule

@@ filelist.f @@
design/pgcd_pkg.sv
design/pinch_glove_contact_decoder.sv
test/pinch_glove_contact_decoder_tb.sv
